FILE: sv/prs_pkg.sv
// ----------------------------------------------------------------------------
// PCM resampler package
// Shared widths, register indexes, sample width codes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

  // Default size of the PCM byte store.
  localparam int STORE_BYTES_DEF = 65536;

  // Field widths.
  localparam int RATE_W     = 18;
  localparam int BITS_W     = 6;
  localparam int CHAN_W     = 4;
  localparam int OFFS_W     = 24;
  localparam int DBYTES_W   = 17;
  localparam int ADDR_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int NTH_W      = 24;
  localparam int SAMP_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Derived arithmetic widths.
  localparam int PROD_W  = RATE_W + NTH_W;          // source_rate * sample_index
  localparam int DIVD_W  = 51;                      // divider dividend width
  localparam int POS_W   = PROD_W + 1;              // source position
  localparam int BC_W    = BITS_W + CHAN_W;         // bits per frame
  localparam int OFF_W   = POS_W + BC_W - 3;        // byte offset
  localparam int DIFF_W  = SAMP_W + 1;              // d2 - d1
  localparam int NPROD_W = DIFF_W + RATE_W + 1;     // (d2 - d1) * remainder

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BYTES    = 3'd5;

  // Supported sample widths.
  localparam logic [BITS_W-1:0] SB_4  = 6'd4;
  localparam logic [BITS_W-1:0] SB_8  = 6'd8;
  localparam logic [BITS_W-1:0] SB_16 = 6'd16;
  localparam logic [BITS_W-1:0] SB_24 = 6'd24;
  localparam logic [BITS_W-1:0] SB_32 = 6'd32;

  // Item operations.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Queued item, as classified by the front end.
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] val;
    logic [PROD_W-1:0] prod;
  } prs_item_t;

  // Configuration registers.
  typedef struct packed {
    logic [RATE_W-1:0]   source_rate;
    logic [RATE_W-1:0]   target_rate;
    logic [BITS_W-1:0]   sample_bits;
    logic [CHAN_W-1:0]   channel_count;
    logic [OFFS_W-1:0]   pos_base;
    logic [DBYTES_W-1:0] data_bytes;
  } prs_cfg_t;

  // Divider response.
  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic [RATE_W-1:0] rem;
  } prs_div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/prs_if.sv
// ----------------------------------------------------------------------------
// PCM resampler channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface prs_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [prs_pkg::ADDR_W-1:0] byte_address;
  logic [prs_pkg::BYTE_W-1:0] byte_value;
  logic [prs_pkg::NTH_W-1:0]  sample_index;

  modport source (output valid, func, byte_address, byte_value, sample_index,
                  input ready);
  modport sink (input valid, func, byte_address, byte_value, sample_index,
                output ready);
endinterface

interface prs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [prs_pkg::SAMP_W-1:0] sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

interface prs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prs_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [prs_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: sv/prs_front.sv
// ----------------------------------------------------------------------------
// PCM resampler front end
// Accepts input words, scales the sample index by the source rate and holds
// the classified item in one register until the queue takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  prs_in_if.sink                          in_ch,
  input  wire logic [prs_pkg::RATE_W-1:0] source_rate,
  output prs_pkg::prs_item_t              item,
  output logic                            item_valid,
  input  wire logic                       item_ready
);
  import prs_pkg::*;

  logic      f_v_r;
  prs_item_t f_item_r;
  logic      take;

  // A word is taken when the stage is empty or empties this cycle.
  assign in_ch.ready = !f_v_r || item_ready;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (take) begin
      f_v_r <= 1'b1;
    end else if (item_ready) begin
      f_v_r <= 1'b0;
    end
  end

  // Payload: the product is only meaningful for fetches.
  always_ff @(posedge clk) begin
    if (take) begin
      f_item_r.func <= in_ch.func;
      f_item_r.addr <= in_ch.byte_address;
      f_item_r.val  <= in_ch.byte_value;
      f_item_r.prod <= PROD_W'(source_rate) * PROD_W'(in_ch.sample_index);
    end
  end

  assign item       = f_item_r;
  assign item_valid = f_v_r;

endmodule

`default_nettype wire

FILE: sv/prs_queue.sv
// ----------------------------------------------------------------------------
// PCM resampler item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prs_pkg::prs_item_t push_item,
  input  wire logic               push_valid,
  output logic                    push_ready,
  output prs_pkg::prs_item_t      pop_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready
);
  import prs_pkg::*;

  prs_item_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/prs_div.sv
// ----------------------------------------------------------------------------
// PCM resampler divider
// Unsigned restoring divider, three quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [prs_pkg::DIVD_W-1:0] dividend,
  input  wire logic [prs_pkg::RATE_W-1:0] divisor,
  output prs_pkg::prs_div_rsp_t           rsp
);
  import prs_pkg::*;

  localparam int BPC   = 3;
  localparam int STEPS = (DIVD_W + BPC - 1) / BPC;
  localparam int PW    = STEPS * BPC;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [PW-1:0]     quo_r;
  logic [RATE_W-1:0] rem_r;
  logic [RATE_W-1:0] dvs_r;
  logic [PW-1:0]     quo_nxt;
  logic [RATE_W:0]   rem_nxt;

  // Three shift-compare-subtract steps on the partial remainder.
  always_comb begin
    rem_nxt = {1'b0, rem_r};
    quo_nxt = quo_r;
    for (int i = 0; i < BPC; i++) begin
      rem_nxt = {rem_nxt[RATE_W-1:0], quo_nxt[PW-1]};
      quo_nxt = {quo_nxt[PW-2:0], 1'b0};
      if (rem_nxt >= {1'b0, dvs_r}) begin
        rem_nxt    = rem_nxt - {1'b0, dvs_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= PW'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt[RATE_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r[DIVD_W-1:0];
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

FILE: sv/prs_back.sv
// ----------------------------------------------------------------------------
// PCM resampler back end
// Owns the byte store, applies writes, and runs fetches: position division,
// byte reads and decoding of two neighbouring samples, then interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_back #(
  parameter int STORE_BYTES = prs_pkg::STORE_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire prs_pkg::prs_cfg_t          cfg,
  input  wire prs_pkg::prs_item_t         q_item,
  input  wire logic                       q_valid,
  output logic                            q_ready,
  output logic                            res_valid,
  output logic signed [prs_pkg::SAMP_W-1:0] res_data,
  input  wire logic                       res_ready
);
  import prs_pkg::*;

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int LW  = OFF_W + 1;
  localparam int MPW = POS_W + BC_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIV1 = 4'd1;
  localparam logic [3:0] ST_POS  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_RDW  = 4'd6;
  localparam logic [3:0] ST_DEC  = 4'd7;
  localparam logic [3:0] ST_MUL2 = 4'd8;
  localparam logic [3:0] ST_ST2  = 4'd9;
  localparam logic [3:0] ST_DIV2 = 4'd10;
  localparam logic [3:0] ST_SUM  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  logic [3:0]              state_r;
  logic [3:0]              state_nxt;
  logic [BYTE_W-1:0]       pcm_mem [STORE_BYTES];
  logic [BYTE_W-1:0]       mem_q_r;
  logic [PROD_W-1:0]       idx_r;
  logic [RATE_W-1:0]       rem_r;
  logic                    k_r;
  logic [POS_W-1:0]        p_r;
  logic [OFF_W-1:0]        off_r;
  logic                    zero_r;
  logic [1:0]              cnt_r;
  logic [3:0][BYTE_W-1:0]  raw_r;
  logic signed [SAMP_W-1:0] d1_r;
  logic signed [SAMP_W-1:0] d2_r;
  logic signed [NPROD_W-1:0] n_r;
  logic                    neg_r;
  logic signed [SAMP_W-1:0] res_r;

  logic                    div_start;
  logic [DIVD_W-1:0]       div_dvd;
  prs_div_rsp_t            div_rsp;
  logic                    wr_en;
  logic                    supported;
  logic [1:0]              need_m1;
  logic [BC_W-1:0]         bc;
  logic [MPW-1:0]          mulp;
  logic [LW-1:0]           lim;
  logic [LW-1:0]           end_off;
  logic [AW-1:0]           rd_addr;
  logic signed [SAMP_W-1:0] dec;
  logic signed [DIFF_W-1:0] diff;
  logic signed [RATE_W:0]  rems;
  logic signed [NPROD_W-1:0] nprod;
  logic [NPROD_W-1:0]      nmag;
  logic [DIFF_W-1:0]       qmag;
  logic [DIFF_W-1:0]       qsgn;
  logic [DIFF_W-1:0]       sum;
  logic                    sel_hi;
  logic [3:0]              nib;

  // Sample width decode: bytes per sample less one, and support.
  always_comb begin
    supported = 1'b1;
    need_m1   = 2'd0;
    unique case (cfg.sample_bits)
      SB_4:    need_m1 = 2'd0;
      SB_8:    need_m1 = 2'd0;
      SB_16:   need_m1 = 2'd1;
      SB_24:   need_m1 = 2'd2;
      SB_32:   need_m1 = 2'd3;
      default: supported = 1'b0;
    endcase
  end

  // Byte offset of the sample and bound check against the valid data.
  assign bc      = BC_W'(cfg.sample_bits) * BC_W'(cfg.channel_count);
  assign mulp    = MPW'(p_r) * MPW'(bc);
  assign end_off = {1'b0, off_r} + LW'(need_m1) + LW'(1);
  always_comb begin
    if (LW'(cfg.data_bytes) < LW'(STORE_BYTES)) begin
      lim = LW'(cfg.data_bytes);
    end else begin
      lim = LW'(STORE_BYTES);
    end
  end

  // Decode the gathered bytes into a Q1.31 sample.
  assign sel_hi = !cfg.channel_count[0] || !p_r[0];
  assign nib    = sel_hi ? raw_r[0][7:4] : raw_r[0][3:0];
  always_comb begin
    dec = '0;
    if (!zero_r) begin
      unique case (cfg.sample_bits)
        SB_4:    dec = {~nib[3], nib[2:0], 28'd0};
        SB_8:    dec = {~raw_r[0][7], raw_r[0][6:0], 24'd0};
        SB_16:   dec = {raw_r[1], raw_r[0], 16'd0};
        SB_24:   dec = {raw_r[2], raw_r[1], raw_r[0], 8'd0};
        SB_32:   dec = {raw_r[3], raw_r[2], raw_r[1], raw_r[0]};
        default: dec = '0;
      endcase
    end
  end

  // Interpolation arithmetic.
  assign diff  = DIFF_W'(d2_r) - DIFF_W'(d1_r);
  assign rems  = {1'b0, rem_r};
  assign nprod = diff * rems;
  assign nmag  = n_r[NPROD_W-1] ? NPROD_W'(-n_r) : NPROD_W'(n_r);
  assign qmag  = div_rsp.quot[DIFF_W-1:0];
  assign qsgn  = neg_r ? (~qmag + DIFF_W'(1)) : qmag;
  assign sum   = DIFF_W'(d1_r) + qsgn;

  // Divider shared by the position and the interpolation step.
  assign div_start = (state_r == ST_IDLE && q_valid && q_item.func == FUNC_FETCH &&
                      cfg.target_rate != '0) || (state_r == ST_ST2);
  assign div_dvd   = (state_r == ST_ST2) ? nmag[DIVD_W-1:0] : DIVD_W'(q_item.prod);

  prs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (cfg.target_rate),
    .rsp      (div_rsp)
  );

  assign q_ready = (state_r == ST_IDLE);
  assign wr_en   = (state_r == ST_IDLE) && q_valid && (q_item.func == FUNC_WRITE) &&
                   (32'(q_item.addr) < 32'(STORE_BYTES));
  assign rd_addr = off_r[AW-1:0] + AW'(cnt_r);

  // Byte store.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pcm_mem[AW'(q_item.addr)] <= q_item.val;
    end
    if (state_r == ST_RD) begin
      mem_q_r <= pcm_mem[rd_addr];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.func == FUNC_FETCH) begin
          state_nxt = (cfg.target_rate == '0) ? ST_FIN : ST_DIV1;
        end
      end
      ST_DIV1: if (div_rsp.done) state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_CHK;
      ST_CHK: begin
        state_nxt = (!supported || end_off > lim) ? ST_DEC : ST_RD;
      end
      ST_RD:   state_nxt = ST_RDW;
      ST_RDW:  state_nxt = (cnt_r == need_m1) ? ST_DEC : ST_RD;
      ST_DEC: begin
        if (k_r) begin
          state_nxt = ST_MUL2;
        end else if (rem_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_POS;
        end
      end
      ST_MUL2: state_nxt = ST_ST2;
      ST_ST2:  state_nxt = ST_DIV2;
      ST_DIV2: if (div_rsp.done) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_FIN;
      ST_FIN:  if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: res_r <= '0;
      ST_DIV1: begin
        idx_r <= div_rsp.quot[PROD_W-1:0];
        rem_r <= div_rsp.rem;
        k_r   <= 1'b0;
      end
      ST_POS:  p_r <= POS_W'(idx_r) + POS_W'(k_r) + POS_W'(cfg.pos_base);
      ST_MUL:  off_r <= mulp[MPW-1:3];
      ST_CHK: begin
        zero_r <= !supported || (end_off > lim);
        cnt_r  <= 2'd0;
      end
      ST_RDW: begin
        raw_r[cnt_r] <= mem_q_r;
        cnt_r        <= cnt_r + 2'd1;
      end
      ST_DEC: begin
        if (k_r) begin
          d2_r <= dec;
        end else begin
          d1_r  <= dec;
          res_r <= dec;
          k_r   <= 1'b1;
        end
      end
      ST_MUL2: n_r <= nprod;
      ST_ST2:  neg_r <= n_r[NPROD_W-1];
      ST_SUM:  res_r <= sum[SAMP_W-1:0];
      default: ;
    endcase
  end

  assign res_valid = (state_r == ST_FIN);
  assign res_data  = res_r;

endmodule

`default_nettype wire

FILE: sv/pcm_linear_resampler.sv
// ----------------------------------------------------------------------------
// PCM linear resampler
// Byte store of little-endian PCM with linear interpolation on fetch.
// ----------------------------------------------------------------------------
// Channels: in_ch carries items; func selects a byte write (byte_address,
// byte_value) or a fetch of output sample sample_index. out_ch returns one
// signed Q1.31 sample_value per fetch and nothing for a write. cfg_ch writes
// the six registers by index and is always ready; the user must use it only
// while idle, as the block does not enforce it. A write passes the front
// register and the queue and is stored once the back end is idle; writes
// flow at one per cycle while it is idle. A fetch runs through the shared
// three-bit-per-cycle divider twice, then reads each byte in a read and a
// capture state from the single store port, its time depending on sample
// width and on whether the samples lie inside the data; a fetch at an exact
// source position skips the second sample and division, and a zero target
// rate answers without division.
// The sequencer in the back end handles one fetch at a time and sets the
// fetch rate; the front end keeps accepting into the two-entry queue.
// Reset clears control state and restores register defaults; the store
// contents are undefined until written. When out_ch stalls, the result
// waits in the output register, the back end holds its next result, and
// the queue and front register fill before in_ch drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_linear_resampler #(
  parameter int STORE_BYTES = prs_pkg::STORE_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  prs_in_if.sink    in_ch,
  prs_out_if.source out_ch,
  prs_cfg_if.sink   cfg_ch
);
  import prs_pkg::*;

  prs_cfg_t                 cfg_r;
  prs_item_t                f_item;
  logic                     f_valid;
  logic                     f_ready;
  prs_item_t                q_item;
  logic                     q_valid;
  logic                     q_ready;
  logic                     res_valid;
  logic                     res_ready;
  logic signed [SAMP_W-1:0] res_data;
  logic                     out_v_r;
  logic signed [SAMP_W-1:0] out_d_r;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_rate   <= RATE_W'(44100);
      cfg_r.target_rate   <= RATE_W'(44100);
      cfg_r.sample_bits   <= SB_16;
      cfg_r.channel_count <= CHAN_W'(1);
      cfg_r.pos_base      <= '0;
      cfg_r.data_bytes    <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        CFG_SOURCE_RATE:   cfg_r.source_rate   <= cfg_ch.wr_data[RATE_W-1:0];
        CFG_TARGET_RATE:   cfg_r.target_rate   <= cfg_ch.wr_data[RATE_W-1:0];
        CFG_SAMPLE_BITS:   cfg_r.sample_bits   <= cfg_ch.wr_data[BITS_W-1:0];
        CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_ch.wr_data[CHAN_W-1:0];
        CFG_START_OFFSET:  cfg_r.pos_base      <= cfg_ch.wr_data[OFFS_W-1:0];
        CFG_DATA_BYTES:    cfg_r.data_bytes    <= cfg_ch.wr_data[DBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  prs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .source_rate (cfg_r.source_rate),
    .item        (f_item),
    .item_valid  (f_valid),
    .item_ready  (f_ready)
  );

  prs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (f_item),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_item   (q_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  prs_back #(
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready)
  );

  // Output register.
  assign res_ready = !out_v_r || out_ch.ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_d_r <= res_data;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.sample_value = out_d_r;

endmodule

`default_nettype wire

FILE: sv/prs_checker.sv
// ----------------------------------------------------------------------------
// PCM resampler port checker
// Checks port behaviour over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [prs_pkg::SAMP_W-1:0] out_data,
  input wire logic                       cfg_ready
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // No result word leaves the block straight after reset.
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered after reset");

  // The input side is free to take a word once reset is released.
  a_in_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port not ready");

  // Sample value must not change under a stall.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

endmodule

bind pcm_linear_resampler prs_checker u_prs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.sample_value),
  .cfg_ready (cfg_ch.ready)
);

`default_nettype wire

FILE: dv/prs_scoreboard.sv
// ----------------------------------------------------------------------------
// PCM resampler scoreboard
// Predicts each fetched sample from its own copy of the store and registers,
// and compares the block's results against the queue of expected samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class prs_scoreboard;
  // Register copy.
  longint unsigned src_rate, tgt_rate, bits, chans, offs, dbytes;
  // Store copy.
  byte unsigned store [int];
  // Expected samples, oldest first.
  logic signed [31:0] want_q[$];
  int fails;

  function void reset_regs();
    src_rate = 44100; tgt_rate = 44100; bits = 16; chans = 1; offs = 0;
    dbytes = 0; fails = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      prs_pkg::CFG_SOURCE_RATE:   src_rate = d[17:0];
      prs_pkg::CFG_TARGET_RATE:   tgt_rate = d[17:0];
      prs_pkg::CFG_SAMPLE_BITS:   bits = d[5:0];
      prs_pkg::CFG_CHANNEL_COUNT: chans = d[3:0];
      prs_pkg::CFG_START_OFFSET:  offs = d[23:0];
      prs_pkg::CFG_DATA_BYTES:    dbytes = d[16:0];
      default: ;
    endcase
  endfunction

  function byte unsigned rd(longint unsigned a);
    return store.exists(int'(a)) ? store[int'(a)] : 8'd0;
  endfunction

  // Decode one source sample at source position s, full scale in Q1.31.
  function longint decoded_sample(longint unsigned s);
    longint unsigned p, o, need, lim, raw;
    longint v;
    p = s + offs;
    o = p * bits * chans / 8;
    if (!(bits == 4 || bits == 8 || bits == 16 || bits == 24 || bits == 32)) return 0;
    need = (bits == 4) ? 1 : bits / 8;
    lim = (dbytes > 65536) ? 65536 : dbytes;
    if (o + need > lim) return 0;
    if (bits == 4) begin
      raw = ((chans & 1) == 0 || (p & 1) == 0) ? (rd(o) >> 4) : (rd(o) & 8'h0f);
      return (longint'(raw) - 8) * (64'sd1 <<< 28);
    end
    if (bits == 8) return (longint'(rd(o)) - 128) * (64'sd1 <<< 24);
    raw = 0;
    for (longint unsigned i = 0; i < need; i++) raw |= longint'(rd(o + i)) << (8 * i);
    if (bits == 16) begin
      v = longint'(raw) - longint'(raw & 16'h8000) * 2;
      return v * 65536;
    end
    if (bits == 24) return (longint'(raw & 24'h7fffff) - longint'(raw & 24'h800000)) * 256;
    return longint'(raw & 32'h7fffffff) - longint'(raw & 32'h80000000);
  endfunction

  // Note an accepted input word.
  function void note_input(logic func, logic [15:0] addr, logic [7:0] val, logic [23:0] nth);
    longint unsigned prod, idx, rem;
    longint d1, d2, res;
    if (func == prs_pkg::FUNC_WRITE) begin
      store[int'(addr)] = val;
      return;
    end
    if (tgt_rate == 0) begin
      want_q.insert(want_q.size(), 32'sd0);
      return;
    end
    prod = src_rate * nth;
    idx = prod / tgt_rate;
    rem = prod % tgt_rate;
    d1 = decoded_sample(idx);
    if (rem == 0) res = d1;
    else begin
      d2 = decoded_sample(idx + 1);
      res = d1 + ((d2 - d1) * longint'(rem)) / longint'(tgt_rate);
    end
    want_q.insert(want_q.size(), res[31:0]);
  endfunction

  // Check one accepted result word.
  function void check_result(logic signed [31:0] got);
    logic signed [31:0] w;
    if (want_q.size() == 0) begin
      $error("sample_value: unexpected result %0d", got);
      fails++;
      return;
    end
    w = want_q.pop_front();
    if (got !== w) begin
      $error("sample_value: expected %0d, actual %0d", w, got);
      fails++;
    end
  endfunction
endclass

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// PCM resampler testbench
// Fills the store with known bytes, sweeps the registers over several phases
// and fetches samples at directed and random indexes, checking every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import prs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  prs_in_if in_ch ();
  prs_out_if out_ch ();
  prs_cfg_if cfg_ch ();
  prs_scoreboard sb = new();
  // Highest store address written so far plus one.
  int filled = 0;

  pcm_linear_resampler DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                            .cfg_ch(cfg_ch));

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Overall limit.
  initial begin
    #200ms;
    $display("Test completed with failures");
    $finish;
  end

  // Write one register while the block is idle; the caller drops valid.
  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    @(negedge clk);
  endtask

  // Send one word, with a random gap before it.
  task automatic send_word(logic func, logic [15:0] addr, logic [7:0] val, logic [23:0] nth);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.byte_address <= addr;
    in_ch.byte_value <= val;
    in_ch.sample_index <= nth;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(func, addr, val, nth);
    if (func == FUNC_WRITE && int'(addr) + 1 > filled) filled = int'(addr) + 1;
    @(negedge clk);
  endtask

  task automatic idle_in();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until all expected samples are in, then let the tail of a write drain.
  task automatic drain();
    idle_in();
    while (sb.want_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // Fill the store from address 0 up to n bytes with random data.
  task automatic fill(int n);
    for (int a = 0; a < n; a++) send_word(FUNC_WRITE, a[15:0], 8'($urandom), 24'($urandom));
  endtask

  // Configure a phase.
  task automatic set_phase(int sr, int tr, int sb_bits, int ch, int off, int db);
    drain();
    write_reg(CFG_SOURCE_RATE, sr);
    write_reg(CFG_TARGET_RATE, tr);
    write_reg(CFG_SAMPLE_BITS, sb_bits);
    write_reg(CFG_CHANNEL_COUNT, ch);
    write_reg(CFG_START_OFFSET, off);
    write_reg(CFG_DATA_BYTES, db);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random fetches, mostly landing inside the stored data.
  task automatic fetches(int n, int span);
    for (int i = 0; i < n; i++)
      send_word(FUNC_FETCH, 16'($urandom), 8'($urandom),
                ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, span)));
  endtask

  // Result side: a random wait before each word, sample at the rising edge.
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    forever begin
      wait_n = $urandom_range(0, 4);
      @(negedge clk);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.sample_value);
    end
  end

  // Stimulus.
  initial begin
    int widths[5] = '{4, 8, 16, 24, 32};
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_WRITE;
    in_ch.byte_address = '0;
    in_ch.byte_value = '0;
    in_ch.sample_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.wr_data = '0;
    sb.reset_regs();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: fetches with an empty data range give zero; extreme bytes.
    send_word(FUNC_FETCH, 16'hffff, 8'hff, 24'hffffff);
    send_word(FUNC_WRITE, 16'h0000, 8'h00, 24'h0);
    send_word(FUNC_WRITE, 16'h0001, 8'h80, 24'h0);
    send_word(FUNC_WRITE, 16'h0002, 8'hff, 24'h0);
    send_word(FUNC_WRITE, 16'h0003, 8'h7f, 24'h0);
    send_word(FUNC_WRITE, 16'hffff, 8'hff, 24'hffffff);
    send_word(FUNC_WRITE, 16'hfffe, 8'h80, 24'h0);
    fill(256);
    for (int w = 0; w < 5; w++) begin
      set_phase(3, 2, widths[w], 1, 0, 256);
      for (int k = 0; k < 5; k++) send_word(FUNC_FETCH, '0, '0, 24'(k));
      // Past the data, unequal rates and the far index.
      send_word(FUNC_FETCH, '0, '0, 24'hffffff);
    end
    // Zero target rate, unsupported width, odd/even channels for nibbles.
    set_phase(5, 0, 16, 1, 0, 256);
    send_word(FUNC_FETCH, '0, '0, 24'd7);
    set_phase(192000, 1, 12, 8, 16777215, 256);
    send_word(FUNC_FETCH, '0, '0, 24'd1);
    set_phase(0, 192000, 4, 3, 1, 256);
    fetches(6, 4);
    set_phase(7, 3, 4, 2, 0, 256);
    fetches(6, 50);
    // Top of the store at maximum data size.
    set_phase(1, 1, 16, 1, 32767, 65536);
    send_word(FUNC_FETCH, '0, '0, 24'd0);

    // Random phases: refresh part of the store, then fetch within it.
    for (int ph = 0; ph < 12; ph++) begin
      int sr, tr, bw, ch, db, fpb;
      drain();
      for (int i = 0; i < 30; i++)
        send_word(FUNC_WRITE, 16'($urandom_range(0, 255)), 8'($urandom), 24'($urandom));
      bw = (ph % 6 == 5) ? $urandom_range(0, 63) : widths[$urandom_range(0, 4)];
      ch = (ph == 3) ? 0 : $urandom_range(1, 8);
      sr = (ph == 0) ? 192000 : (ph == 1) ? 1 : $urandom_range(1, 48000);
      tr = (ph == 2) ? 192000 : (ph == 4) ? 1 : $urandom_range(1, 48000);
      db = $urandom_range(0, 256);
      fpb = (bw > 0 && ch > 0) ? (bw * ch + 7) / 8 : 1;
      set_phase(sr, tr, bw, ch, $urandom_range(0, 3), db);
      fetches(75, (256 / fpb) * tr / sr + 2);
    end
    drain();
    if (sb.fails == 0 && sb.want_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
